// ===== rtl/gtl_pkg.sv =====
`timescale 1ns / 1ps

package gtl_pkg;

    // Display command bytes and masks.
    localparam logic [7:0] CMD_PAGE    = 8'hB8;
    localparam logic [7:0] CMD_COLUMN  = 8'h40;
    localparam logic [7:0] PAGE_MASK   = 8'h07;
    localparam logic [7:0] COLUMN_MASK = 8'h3F;

    // Character code classes.
    localparam logic [7:0] LINE_LAST       = 8'd8;
    localparam logic [7:0] TERMINAL_CODE   = 8'd9;
    localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
    localparam logic [7:0] LAST_PRINTABLE  = 8'd127;
    localparam logic [7:0] DEGREE_CODE     = 8'd176;
    localparam logic [6:0] DEGREE_INDEX    = 7'd96;

    // Write targets.
    localparam logic [1:0] TGT_LEFT   = 2'd0;
    localparam logic [1:0] TGT_RIGHT  = 2'd1;
    localparam logic [1:0] TGT_SERIAL = 2'd2;

    // Steps of each write sequence.
    localparam logic [2:0] LINE_STEP_LAST  = 3'd3;
    localparam logic [2:0] GLYPH_COLS      = 3'd5;
    localparam logic [2:0] GLYPH_STEP_LAST = 3'd7;

    typedef enum logic [1:0] {
        K_LINE,
        K_SERIAL,
        K_GLYPH
    } t_kind;

    // One classified item as it waits between the front and the back end.
    // For a line select, value holds the page; for a serial byte, the code;
    // for a character cell, the font index.
    typedef struct packed {
        t_kind      kind;
        logic       right;
        logic [7:0] value;
    } t_cmd;

    // Map a character code to its row in the font.
    function automatic logic [6:0] font_index(input logic [7:0] code);
        logic [7:0] diff;
        diff = code - FIRST_PRINTABLE;
        if (code >= FIRST_PRINTABLE && code <= LAST_PRINTABLE) begin
            font_index = diff[6:0];
        end else if (code == DEGREE_CODE) begin
            font_index = DEGREE_INDEX;
        end else begin
            font_index = 7'd0;
        end
    endfunction

    // 5x7 font: column 0 in the top byte, column 4 in the bottom byte.
    function automatic logic [39:0] font_row(input logic [6:0] idx);
        logic [39:0] row;
        unique case (idx)
            7'd0:  row = 40'h0000000000;
            7'd1:  row = 40'h00005F0000;
            7'd2:  row = 40'h0007000700;
            7'd3:  row = 40'h147F147F14;
            7'd4:  row = 40'h242A7F2A12;
            7'd5:  row = 40'h2313086462;
            7'd6:  row = 40'h3649552250;
            7'd7:  row = 40'h0005030000;
            7'd8:  row = 40'h001C224100;
            7'd9:  row = 40'h0041221C00;
            7'd10: row = 40'h082A1C2A08;
            7'd11: row = 40'h08083E0808;
            7'd12: row = 40'h0050300000;
            7'd13: row = 40'h0808080808;
            7'd14: row = 40'h0030300000;
            7'd15: row = 40'h2010080402;
            7'd16: row = 40'h3E5149453E;
            7'd17: row = 40'h00427F4000;
            7'd18: row = 40'h4261514946;
            7'd19: row = 40'h2141454B31;
            7'd20: row = 40'h1814127F10;
            7'd21: row = 40'h2745454539;
            7'd22: row = 40'h3C4A494930;
            7'd23: row = 40'h0171090503;
            7'd24: row = 40'h3649494936;
            7'd25: row = 40'h064949291E;
            7'd26: row = 40'h0036360000;
            7'd27: row = 40'h0056360000;
            7'd28: row = 40'h0008142241;
            7'd29: row = 40'h1414141414;
            7'd30: row = 40'h4122140800;
            7'd31: row = 40'h0201510906;
            7'd32: row = 40'h324979413E;
            7'd33: row = 40'h7E1111117E;
            7'd34: row = 40'h7F49494936;
            7'd35: row = 40'h3E41414122;
            7'd36: row = 40'h7F4141221C;
            7'd37: row = 40'h7F49494941;
            7'd38: row = 40'h7F09090101;
            7'd39: row = 40'h3E41415132;
            7'd40: row = 40'h7F0808087F;
            7'd41: row = 40'h00417F4100;
            7'd42: row = 40'h2040413F01;
            7'd43: row = 40'h7F08142241;
            7'd44: row = 40'h7F40404040;
            7'd45: row = 40'h7F0204027F;
            7'd46: row = 40'h7F0408107F;
            7'd47: row = 40'h3E4141413E;
            7'd48: row = 40'h7F09090906;
            7'd49: row = 40'h3E4151215E;
            7'd50: row = 40'h7F09192946;
            7'd51: row = 40'h4649494931;
            7'd52: row = 40'h01017F0101;
            7'd53: row = 40'h3F4040403F;
            7'd54: row = 40'h1F2040201F;
            7'd55: row = 40'h7F2018207F;
            7'd56: row = 40'h6314081463;
            7'd57: row = 40'h0304780403;
            7'd58: row = 40'h6151494543;
            7'd59: row = 40'h00007F4141;
            7'd60: row = 40'h0204081020;
            7'd61: row = 40'h41417F0000;
            7'd62: row = 40'h0402010204;
            7'd63: row = 40'h4040404040;
            7'd64: row = 40'h0001020400;
            7'd65: row = 40'h2054545478;
            7'd66: row = 40'h7F48444438;
            7'd67: row = 40'h3844444420;
            7'd68: row = 40'h384444487F;
            7'd69: row = 40'h3854545418;
            7'd70: row = 40'h087E090102;
            7'd71: row = 40'h081454543C;
            7'd72: row = 40'h7F08040478;
            7'd73: row = 40'h00447D4000;
            7'd74: row = 40'h2040443D00;
            7'd75: row = 40'h007F102844;
            7'd76: row = 40'h00417F4000;
            7'd77: row = 40'h7C04180478;
            7'd78: row = 40'h7C08040478;
            7'd79: row = 40'h3844444438;
            7'd80: row = 40'h7C14141408;
            7'd81: row = 40'h081414187C;
            7'd82: row = 40'h7C08040408;
            7'd83: row = 40'h4854545420;
            7'd84: row = 40'h043F444020;
            7'd85: row = 40'h3C4040207C;
            7'd86: row = 40'h1C2040201C;
            7'd87: row = 40'h3C4030403C;
            7'd88: row = 40'h4428102844;
            7'd89: row = 40'h0C5050503C;
            7'd90: row = 40'h4464544C44;
            7'd91: row = 40'h0008364100;
            7'd92: row = 40'h00007F0000;
            7'd93: row = 40'h0041360800;
            7'd94: row = 40'h08082A1C08;
            7'd95: row = 40'h081C2A0808;
            7'd96: row = 40'h0007050700;
            default: row = 40'h0000000000;
        endcase
        font_row = row;
    endfunction

endpackage

// ===== rtl/glyph_text_to_lcd_writes.sv =====
`timescale 1ns / 1ps

// Turns a stream of character codes into write transfers for a two-controller
// 128x64 graphic LCD plus a serial port. A line code (0 to 8) gives four
// command writes, code 9 and every code above 8 in terminal mode give one serial byte,
// and any other code gives eight glyph column writes on the left or right
// half. The back end issues one write per clock while the consumer does not stall,
// and the first write of an item passes the queue and then the output register
// before it appears on the output. An input transfer is taken
// in the same cycle whenever the two-entry queue between the code classifier
// and the write sequencer has room; a stalled consumer holds the sequencer,
// and input stops once two items wait in the queue.
module glyph_text_to_lcd_writes #(
    parameter int CHARS_PER_HALF = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_code,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_target,
    output logic       o_is_data,
    output logic [7:0] o_out_byte,
    output logic       o_last
);
    import gtl_pkg::*;

    logic full;
    logic empty;
    logic push;
    logic pop;
    t_cmd cmd;
    t_cmd head;

    // Classifier: accepts codes and keeps the line state.
    gtl_front #(
        .CHARS_PER_HALF(CHARS_PER_HALF)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_char_code (i_char_code),
        .i_full      (full),
        .o_push      (push),
        .o_cmd       (cmd)
    );

    // Queue between classifier and sequencer.
    gtl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    // Sequencer: one write transfer per cycle while an item waits and the consumer does not stall.
    gtl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_target    (o_target),
        .o_is_data   (o_is_data),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule

// ===== rtl/gtl_front.sv =====
`timescale 1ns / 1ps

module gtl_front #(
    parameter int CHARS_PER_HALF = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [7:0]    i_char_code,
    input  logic          i_full,
    output logic          o_push,
    output gtl_pkg::t_cmd o_cmd
);
    import gtl_pkg::*;

    logic [7:0] r_char_count;
    logic       r_terminal;
    logic [7:0] n_char_count;
    logic       n_terminal;
    logic [7:0] page;

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;
    assign page       = (i_char_code - 8'd1) & PAGE_MASK;

    // Classify the incoming code and work out the line state it leaves.
    always_comb begin
        n_char_count = r_char_count;
        n_terminal   = r_terminal;
        o_cmd.right  = 1'b0;
        if (i_char_code <= LINE_LAST) begin
            o_cmd.kind   = K_LINE;
            o_cmd.value  = page;
            n_char_count = 8'd0;
            n_terminal   = 1'b0;
        end else if (i_char_code == TERMINAL_CODE || r_terminal) begin
            o_cmd.kind  = K_SERIAL;
            o_cmd.value = i_char_code;
            n_terminal  = 1'b1;
        end else begin
            o_cmd.kind   = K_GLYPH;
            o_cmd.right  = !(r_char_count < 8'(CHARS_PER_HALF));
            o_cmd.value  = {1'b0, font_index(i_char_code)};
            n_char_count = r_char_count + 8'd1;
        end
    end

    // Line state advances on each accepted transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_count <= 8'd0;
            r_terminal   <= 1'b0;
        end else if (o_push) begin
            r_char_count <= n_char_count;
            r_terminal   <= n_terminal;
        end
    end

endmodule

// ===== rtl/gtl_fifo.sv =====
`timescale 1ns / 1ps

module gtl_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gtl_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output gtl_pkg::t_cmd o_head
);
    import gtl_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_head  = r_mem[r_rd_ptr];

    // Two-entry queue storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/gtl_back.sv =====
`timescale 1ns / 1ps

module gtl_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  gtl_pkg::t_cmd i_head,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [1:0]    o_target,
    output logic          o_is_data,
    output logic [7:0]    o_out_byte,
    output logic          o_last
);
    import gtl_pkg::*;

    logic [2:0]  r_step;
    logic        r_out_valid;
    logic [1:0]  r_target;
    logic        r_is_data;
    logic [7:0]  r_out_byte;
    logic        r_last;

    logic        load;
    logic        fire;
    logic [1:0]  n_target;
    logic        n_is_data;
    logic [7:0]  n_out_byte;
    logic        n_last;
    logic [39:0] glyph;
    logic [7:0]  column;
    logic [7:0]  page_cmd;
    logic [7:0]  col_cmd;

    assign load  = !r_out_valid || i_out_ready;
    assign fire  = load && !i_empty;
    assign o_pop = fire && n_last;

    assign glyph    = font_row(i_head.value[6:0]);
    assign page_cmd = CMD_PAGE | (i_head.value & PAGE_MASK);
    assign col_cmd  = CMD_COLUMN | (8'd0 & COLUMN_MASK);

    // Pick the glyph column for the current step; trailing columns are blank.
    always_comb begin
        case (r_step)
            3'd0:    column = glyph[39:32];
            3'd1:    column = glyph[31:24];
            3'd2:    column = glyph[23:16];
            3'd3:    column = glyph[15:8];
            3'd4:    column = glyph[7:0];
            default: column = 8'd0;
        endcase
    end

    // Result for the current step of the item at the head of the queue.
    always_comb begin
        unique case (i_head.kind)
            K_LINE: begin
                n_target   = r_step[1] ? TGT_RIGHT : TGT_LEFT;
                n_is_data  = 1'b0;
                n_out_byte = r_step[0] ? col_cmd : page_cmd;
                n_last     = r_step == LINE_STEP_LAST;
            end
            K_SERIAL: begin
                n_target   = TGT_SERIAL;
                n_is_data  = 1'b1;
                n_out_byte = i_head.value;
                n_last     = 1'b1;
            end
            K_GLYPH: begin
                n_target   = i_head.right ? TGT_RIGHT : TGT_LEFT;
                n_is_data  = 1'b1;
                n_out_byte = (r_step < GLYPH_COLS) ? column : 8'd0;
                n_last     = r_step == GLYPH_STEP_LAST;
            end
            default: begin
                n_target   = TGT_SERIAL;
                n_is_data  = 1'b1;
                n_out_byte = 8'd0;
                n_last     = 1'b1;
            end
        endcase
    end

    // Step counter and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= 3'd0;
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_step      <= n_last ? 3'd0 : r_step + 3'd1;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload of the output register.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_target   <= n_target;
            r_is_data  <= n_is_data;
            r_out_byte <= n_out_byte;
            r_last     <= n_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_target    = r_target;
    assign o_is_data   = r_is_data;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_last;

endmodule

// ===== bench/glyph_text_to_lcd_writes_test.sv =====
`timescale 1ns / 1ps

module glyph_text_to_lcd_writes_test;
    import gtl_pkg::*;

    localparam int CHARS_PER_HALF = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;
    localparam int RANDOM_PER_PHASE = 52;

    // One write transfer as seen on the result channel.
    typedef struct {
        logic [1:0] target;
        logic       is_data;
        logic [7:0] value;
        logic       last;
    } t_lcd_write;

    // Predicts the write transfers for each accepted character code and
    // checks the transfers that leave the block against them, in order.
    class t_lcd_write_scoreboard;
        t_lcd_write  pending[$];
        logic [7:0]  chars_on_line;
        logic        terminal_on;
        logic [39:0] glyphs [97];
        int          failures;

        function new();
            chars_on_line = 8'd0;
            terminal_on   = 1'b0;
            failures      = 0;
            // Column 0 sits in the top byte of each row.
            glyphs = '{
                40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
                40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
                40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
                40'h0050300000, 40'h0808080808, 40'h0030300000, 40'h2010080402,
                40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
                40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
                40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
                40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
                40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
                40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
                40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
                40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
                40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
                40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
                40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
                40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040,
                40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
                40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h081454543C,
                40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h007F102844,
                40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
                40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
                40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
                40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
                40'h00007F0000, 40'h0041360800, 40'h08082A1C08, 40'h081C2A0808,
                40'h0007050700
            };
        endfunction

        function void add_write(logic [1:0] target, logic is_data, logic [7:0] value,
                                logic last);
            t_lcd_write w;
            w.target  = target;
            w.is_data = is_data;
            w.value   = value;
            w.last    = last;
            pending.push_back(w);
        endfunction

        // Work out the writes that one accepted character code causes.
        function void note_code(logic [7:0] code);
            logic [7:0] page_cmd;
            logic [1:0] half;
            int         row;
            if (code <= LINE_LAST) begin
                // Line select wins over terminal mode and restarts the line.
                page_cmd = CMD_PAGE | ((code - 8'd1) & PAGE_MASK);
                add_write(TGT_LEFT, 1'b0, page_cmd, 1'b0);
                add_write(TGT_LEFT, 1'b0, CMD_COLUMN, 1'b0);
                add_write(TGT_RIGHT, 1'b0, page_cmd, 1'b0);
                add_write(TGT_RIGHT, 1'b0, CMD_COLUMN, 1'b1);
                chars_on_line = 8'd0;
                terminal_on   = 1'b0;
            end else if (code == TERMINAL_CODE || terminal_on) begin
                terminal_on = 1'b1;
                add_write(TGT_SERIAL, 1'b1, code, 1'b1);
            end else begin
                // Character cell: five glyph columns, then three blank ones.
                half = (chars_on_line < CHARS_PER_HALF) ? TGT_LEFT : TGT_RIGHT;
                if (code >= FIRST_PRINTABLE && code <= LAST_PRINTABLE) begin
                    row = code - FIRST_PRINTABLE;
                end else if (code == DEGREE_CODE) begin
                    row = DEGREE_INDEX;
                end else begin
                    row = 0;
                end
                for (int k = 0; k < 8; k++) begin
                    add_write(half, 1'b1, (k < 5) ? glyphs[row][39 - 8 * k -: 8] : 8'h00,
                              k == 7);
                end
                chars_on_line = chars_on_line + 8'd1;
            end
        endfunction

        // Compare one write transfer with the oldest one still expected.
        function void check_write(t_lcd_write got);
            t_lcd_write exp_w;
            if (pending.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("unexpected write: target %0d is_data %0b byte %02h last %0b",
                             got.target, got.is_data, got.value, got.last);
                end
                return;
            end
            exp_w = pending.pop_front();
            if (got.target !== exp_w.target || got.is_data !== exp_w.is_data ||
                got.value !== exp_w.value || got.last !== exp_w.last) begin
                failures++;
                if (failures <= 10) begin
                    $display("write mismatch: expected target %0d is_data %0b byte %02h last %0b",
                             exp_w.target, exp_w.is_data, exp_w.value, exp_w.last);
                    $display("                got target %0d is_data %0b byte %02h last %0b",
                             got.target, got.is_data, got.value, got.last);
                end
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_char_code = 8'd0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [1:0] o_target;
    logic       o_is_data;
    logic [7:0] o_out_byte;
    logic       o_last;

    t_lcd_write_scoreboard sb = new();
    int send_idle_pct = 15;
    int recv_stall_pct = 66;
    int quiet_cycles = 0;

    glyph_text_to_lcd_writes #(
        .CHARS_PER_HALF(CHARS_PER_HALF)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_char_code(i_char_code),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_target   (o_target),
        .o_is_data  (o_is_data),
        .o_out_byte (o_out_byte),
        .o_last     (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls, and a check of every write transfer.
    always @(posedge i_clk) begin
        t_lcd_write got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.target  = o_target;
            got.is_data = o_is_data;
            got.value   = o_out_byte;
            got.last    = o_last;
            sb.check_write(got);
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one code, with a random idle gap first, and hold it until taken.
    task automatic send_code(input logic [7:0] code);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid  <= 1'b1;
        i_char_code <= code;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        sb.note_code(code);
    endtask

    // Mostly printable text, with line selects and terminal entries mixed in.
    function automatic logic [7:0] pick_code();
        int r;
        r = $urandom_range(99);
        if (r < 10) begin
            return 8'($urandom_range(LINE_LAST));
        end else if (r < 16) begin
            return TERMINAL_CODE;
        end else if (r < 20) begin
            return DEGREE_CODE;
        end else if (r < 65) begin
            return 8'($urandom_range(LAST_PRINTABLE, FIRST_PRINTABLE));
        end else begin
            return 8'($urandom_range(255));
        end
    endfunction

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++) begin
            send_code(pick_code());
        end
    endtask

    initial begin
        logic [7:0] directed_codes [23];
        directed_codes = '{
            8'd0, 8'd1, LINE_LAST,
            // Ten cells on one line so the last two land on the right half.
            FIRST_PRINTABLE, LAST_PRINTABLE, DEGREE_CODE, 8'd255, 8'd31, 8'd128,
            8'd65, 8'd66, 8'd67, 8'd68,
            // Terminal mode, a repeated terminal code, then a line select to leave it.
            TERMINAL_CODE, 8'd200, TERMINAL_CODE, 8'd0, 8'd5,
            8'd2, 8'd3, 8'd4, 8'd6, 8'd7
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sender idles a little, receiver stalls a lot.
        send_idle_pct  = 15;
        recv_stall_pct = 66;
        foreach (directed_codes[i]) begin
            send_code(directed_codes[i]);
        end
        send_random(RANDOM_PER_PHASE);

        // Sender idles a lot, receiver stalls a little.
        send_idle_pct  = 66;
        recv_stall_pct = 15;
        send_random(RANDOM_PER_PHASE);

        // Full rate both ways.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random(RANDOM_PER_PHASE);
        i_in_valid <= 1'b0;

        while (sb.pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.failures == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/gtl_pkg.sv
rtl/gtl_front.sv
rtl/gtl_fifo.sv
rtl/gtl_back.sv
rtl/glyph_text_to_lcd_writes.sv
bench/glyph_text_to_lcd_writes_test.sv
